// File: hdl/aln_pkg.sv
// ----------------------------------------------------------------------------
// aln_pkg
// Shared types and constants of the adaptive level normalizer.
// ----------------------------------------------------------------------------
package aln_pkg;

    // Fixed field widths of the channels and configuration registers
    localparam int IN_W    = 32;
    localparam int LEVEL_W = 10;
    localparam int SHIFT_W = 5;
    localparam int SPAN_W  = 16;
    localparam int CFG_W   = 16;

    // Register reset values
    localparam logic [SHIFT_W-1:0] RST_FLOOR_RISE = 5'd7;
    localparam logic [SHIFT_W-1:0] RST_FLOOR_FALL = 5'd3;
    localparam logic [SHIFT_W-1:0] RST_PEAK_DECAY = 5'd6;
    localparam logic [SPAN_W-1:0]  RST_MIN_SPAN   = 16'd128;

    typedef enum logic [1:0] {
        CFG_FLOOR_RISE = 2'd0,
        CFG_FLOOR_FALL = 2'd1,
        CFG_PEAK_DECAY = 2'd2,
        CFG_MIN_SPAN   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [SHIFT_W-1:0] floor_rise_shift;
        logic [SHIFT_W-1:0] floor_fall_shift;
        logic [SHIFT_W-1:0] peak_decay_shift;
        logic [SPAN_W-1:0]  min_span;
    } t_cfg;

    typedef enum logic [2:0] {
        LANE_IDLE,
        LANE_FLOOR,
        LANE_SIG,
        LANE_PEAK,
        LANE_SPAN,
        LANE_DIV,
        LANE_SMOOTH,
        LANE_DONE
    } t_lane_state;

endpackage

// File: hdl/aln_in_if.sv
// ----------------------------------------------------------------------------
// aln_in_if
// Input channel: one pair of frame energies per transaction.
// ----------------------------------------------------------------------------
interface aln_in_if;
    logic                      valid;
    logic                      ready;
    logic [aln_pkg::IN_W-1:0]  music_energy;
    logic [aln_pkg::IN_W-1:0]  activity_energy;

    modport source (output valid, output music_energy, output activity_energy, input ready);
    modport sink   (input valid, input music_energy, input activity_energy, output ready);
endinterface

// File: hdl/aln_out_if.sv
// ----------------------------------------------------------------------------
// aln_out_if
// Output channel: one pair of smoothed levels per transaction.
// ----------------------------------------------------------------------------
interface aln_out_if;
    logic                         valid;
    logic                         ready;
    logic [aln_pkg::LEVEL_W-1:0]  music_level;
    logic [aln_pkg::LEVEL_W-1:0]  activity_level;

    modport source (output valid, output music_level, output activity_level, input ready);
    modport sink   (input valid, input music_level, input activity_level, output ready);
endinterface

// File: hdl/aln_lane.sv
// ----------------------------------------------------------------------------
// aln_lane
// One normalizer lane: floor tracker, peak tracker, radix-2 permille divider
// and attack/release smoother, stepped by a small sequencer.
// ----------------------------------------------------------------------------
module aln_lane #(
    parameter int ENERGY_WIDTH = 32,
    parameter int FULL_SCALE   = 1000,
    parameter int LW           = $clog2(FULL_SCALE + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [ENERGY_WIDTH-1:0] i_x,
    input  aln_pkg::t_cfg           i_cfg,
    input  logic                    i_ack,
    output logic                    o_done,
    output logic [LW-1:0]           o_level
);
    localparam int EW = ENERGY_WIDTH;
    localparam int BW = $clog2(LW);
    localparam logic [LW-1:0] FS_V = LW'(FULL_SCALE);

    aln_pkg::t_lane_state r_state, n_state;

    logic [EW-1:0] r_x, n_x;
    logic [EW-1:0] r_floor, n_floor;
    logic [EW-1:0] r_peak, n_peak;
    logic [EW-1:0] r_sig, n_sig;
    logic [EW:0]   r_decay, n_decay;
    logic [EW-1:0] r_span, n_span;
    logic [EW-1:0] r_rem, n_rem;
    logic [LW-1:0] r_quo, n_quo;
    logic [BW-1:0] r_bit, n_bit;
    logic          r_full, n_full;
    logic [LW-1:0] r_level, n_level;

    logic [EW-1:0] w_diff;
    logic [EW-1:0] w_min_span;
    logic [EW-1:0] w_p1;
    logic [EW-1:0] w_p2;
    logic [EW+1:0] w_t;
    logic [EW+1:0] w_span1;
    logic [EW+1:0] w_span2;
    logic [1:0]    w_k;
    logic [LW-1:0] w_tgt;
    logic [LW-1:0] w_gap;
    logic [LW+1:0] w_up_step;
    logic [LW:0]   w_dn_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aln_pkg::LANE_IDLE;
            r_floor <= '0;
            r_peak  <= EW'(1);
            r_level <= '0;
        end else begin
            r_state <= n_state;
            r_floor <= n_floor;
            r_peak  <= n_peak;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_sig   <= n_sig;
        r_decay <= n_decay;
        r_span  <= n_span;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_bit   <= n_bit;
        r_full  <= n_full;
    end

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_floor = r_floor;
        n_peak  = r_peak;
        n_sig   = r_sig;
        n_decay = r_decay;
        n_span  = r_span;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_bit   = r_bit;
        n_full  = r_full;
        n_level = r_level;

        w_diff     = (r_x >= r_floor) ? (r_x - r_floor) : (r_floor - r_x);
        w_min_span = EW'(i_cfg.min_span);

        // Peak decays toward one, then is lifted back by the current signal.
        w_p1 = ({1'b0, r_peak} > r_decay) ? (r_peak - r_decay[EW-1:0]) : EW'(1);
        w_p2 = (r_sig > w_p1) ? r_sig : w_p1;

        // Each divider step doubles the running remainder and adds the signal
        // when the scale bit is set; the sum stays below three times the span.
        w_span1 = {2'b00, r_span};
        w_span2 = {1'b0, r_span, 1'b0};
        w_t     = {1'b0, r_rem, 1'b0} + (FS_V[r_bit] ? {2'b00, r_sig} : '0);
        if (w_t >= w_span2) begin
            w_k = 2'd2;
        end else if (w_t >= w_span1) begin
            w_k = 2'd1;
        end else begin
            w_k = 2'd0;
        end

        w_tgt     = r_full ? FS_V : r_quo;
        w_gap     = (w_tgt > r_level) ? (w_tgt - r_level) : (r_level - w_tgt);
        w_up_step = ({1'b0, w_gap, 1'b0} + {2'b00, w_gap} + (LW+2)'(3)) >> 2;
        w_dn_step = ({1'b0, w_gap} + (LW+1)'(7)) >> 3;

        unique case (r_state)
            aln_pkg::LANE_IDLE: begin
                if (i_start) begin
                    n_x     = i_x;
                    n_state = aln_pkg::LANE_FLOOR;
                end
            end
            aln_pkg::LANE_FLOOR: begin
                if (r_x >= r_floor) begin
                    n_floor = r_floor + (w_diff >> i_cfg.floor_rise_shift);
                end else begin
                    n_floor = r_floor - (w_diff >> i_cfg.floor_fall_shift);
                end
                n_state = aln_pkg::LANE_SIG;
            end
            aln_pkg::LANE_SIG: begin
                n_sig   = (r_x > r_floor) ? (r_x - r_floor) : '0;
                n_decay = {1'b0, r_peak >> i_cfg.peak_decay_shift} + (EW+1)'(1);
                n_state = aln_pkg::LANE_PEAK;
            end
            aln_pkg::LANE_PEAK: begin
                n_peak = (r_sig >= r_peak) ? r_sig : w_p2;
                if (n_peak == '0) begin
                    n_peak = EW'(1);
                end
                n_state = aln_pkg::LANE_SPAN;
            end
            aln_pkg::LANE_SPAN: begin
                n_span  = (r_peak < w_min_span) ? w_min_span : r_peak;
                n_rem   = '0;
                n_quo   = '0;
                n_bit   = BW'(LW - 1);
                n_state = aln_pkg::LANE_DIV;
            end
            aln_pkg::LANE_DIV: begin
                if (w_k == 2'd2) begin
                    n_rem = EW'(w_t - w_span2);
                end else if (w_k == 2'd1) begin
                    n_rem = EW'(w_t - w_span1);
                end else begin
                    n_rem = EW'(w_t);
                end
                n_quo  = {r_quo[LW-2:0], 1'b0} + LW'(w_k);
                n_full = (r_sig >= r_span);
                if (r_bit == '0) begin
                    n_state = aln_pkg::LANE_SMOOTH;
                end else begin
                    n_bit = r_bit - BW'(1);
                end
            end
            aln_pkg::LANE_SMOOTH: begin
                if (w_tgt > r_level) begin
                    n_level = r_level + LW'(w_up_step);
                end else if (w_tgt < r_level) begin
                    n_level = r_level - LW'(w_dn_step);
                end
                n_state = aln_pkg::LANE_DONE;
            end
            aln_pkg::LANE_DONE: begin
                if (i_ack) begin
                    n_state = aln_pkg::LANE_IDLE;
                end
            end
            default: n_state = aln_pkg::LANE_IDLE;
        endcase
    end

    assign o_done  = (r_state == aln_pkg::LANE_DONE);
    assign o_level = r_level;

endmodule

// File: hdl/aln_merge.sv
// ----------------------------------------------------------------------------
// aln_merge
// Joins the two lane results into one output register and drives the
// output channel.
// ----------------------------------------------------------------------------
module aln_merge #(
    parameter int LW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_music_done,
    input  logic [LW-1:0] i_music_level,
    input  logic          i_activity_done,
    input  logic [LW-1:0] i_activity_level,
    output logic          o_taken,
    aln_out_if.source     o_out
);
    logic                         r_valid;
    logic [aln_pkg::LEVEL_W-1:0]  r_music;
    logic [aln_pkg::LEVEL_W-1:0]  r_activity;

    // Capture once both lanes are finished and the register is free or draining.
    assign o_taken = i_music_done && i_activity_done && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_taken) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_taken) begin
            r_music    <= aln_pkg::LEVEL_W'(i_music_level);
            r_activity <= aln_pkg::LEVEL_W'(i_activity_level);
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.music_level    = r_music;
    assign o_out.activity_level = r_activity;

endmodule

// File: hdl/adaptive_level_normalizer_core.sv
// ----------------------------------------------------------------------------
// adaptive_level_normalizer_core
// Two-lane adaptive level normalizer with attack/release smoothing.
// ----------------------------------------------------------------------------
// Each input transaction carries a music and an activity energy; two identical
// lanes track a noise floor and a decaying peak, scale the signal above the
// floor to permille of max(peak, min_span) and smooth the result with fast
// attack and slow release. One item is handled at a time: the lanes' permille
// divider produces one quotient bit per cycle, and the next item is taken the
// cycle after the result enters the output register, which may still be
// waiting on the consumer. Configuration writes take effect at once and must
// only be made while the block is idle.
// ----------------------------------------------------------------------------
module adaptive_level_normalizer_core #(
    parameter int ENERGY_WIDTH = 32,
    parameter int FULL_SCALE   = 1000
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    aln_in_if.sink                      i_in,
    aln_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  aln_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [aln_pkg::CFG_W-1:0]   i_cfg_data
);
    localparam int LW = $clog2(FULL_SCALE + 1);

    aln_pkg::t_cfg r_cfg;
    logic          r_busy;
    logic          w_start;
    logic          w_taken;
    logic          w_music_done;
    logic          w_activity_done;
    logic [LW-1:0] w_music_level;
    logic [LW-1:0] w_activity_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.floor_rise_shift <= aln_pkg::RST_FLOOR_RISE;
            r_cfg.floor_fall_shift <= aln_pkg::RST_FLOOR_FALL;
            r_cfg.peak_decay_shift <= aln_pkg::RST_PEAK_DECAY;
            r_cfg.min_span         <= aln_pkg::RST_MIN_SPAN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                aln_pkg::CFG_FLOOR_RISE:
                    r_cfg.floor_rise_shift <= i_cfg_data[aln_pkg::SHIFT_W-1:0];
                aln_pkg::CFG_FLOOR_FALL:
                    r_cfg.floor_fall_shift <= i_cfg_data[aln_pkg::SHIFT_W-1:0];
                aln_pkg::CFG_PEAK_DECAY:
                    r_cfg.peak_decay_shift <= i_cfg_data[aln_pkg::SHIFT_W-1:0];
                aln_pkg::CFG_MIN_SPAN:
                    r_cfg.min_span         <= i_cfg_data[aln_pkg::SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // Busy from the input transaction until the merge stage captures the result.
    assign i_in.ready = !r_busy;
    assign w_start    = i_in.valid && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_start) begin
            r_busy <= 1'b1;
        end else if (w_taken) begin
            r_busy <= 1'b0;
        end
    end

    aln_lane #(
        .ENERGY_WIDTH (ENERGY_WIDTH),
        .FULL_SCALE   (FULL_SCALE),
        .LW           (LW)
    ) u_music_lane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_x     (ENERGY_WIDTH'(i_in.music_energy)),
        .i_cfg   (r_cfg),
        .i_ack   (w_taken),
        .o_done  (w_music_done),
        .o_level (w_music_level)
    );

    aln_lane #(
        .ENERGY_WIDTH (ENERGY_WIDTH),
        .FULL_SCALE   (FULL_SCALE),
        .LW           (LW)
    ) u_activity_lane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_x     (ENERGY_WIDTH'(i_in.activity_energy)),
        .i_cfg   (r_cfg),
        .i_ack   (w_taken),
        .o_done  (w_activity_done),
        .o_level (w_activity_level)
    );

    aln_merge #(
        .LW (LW)
    ) u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_music_done     (w_music_done),
        .i_music_level    (w_music_level),
        .i_activity_done  (w_activity_done),
        .i_activity_level (w_activity_level),
        .o_taken          (w_taken),
        .o_out            (o_out)
    );

endmodule

// File: sim/aln_level_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aln_level_checker
// Watches both channels and the register port of the level normalizer, works
// out the expected music and activity levels for every input transaction and
// compares them field by field with the output transactions, in order.
// ----------------------------------------------------------------------------
module aln_level_checker #(
    parameter int ENERGY_WIDTH = 32,
    parameter int FULL_SCALE   = 1000
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    aln_in_if                           i_in_mon,
    aln_out_if                          i_out_mon,
    input  logic                        i_cfg_we,
    input  aln_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [aln_pkg::CFG_W-1:0]   i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    localparam logic [63:0] ENERGY_MASK =
        (ENERGY_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << ENERGY_WIDTH) - 64'd1);

    typedef struct packed {
        logic [aln_pkg::LEVEL_W-1:0] music;
        logic [aln_pkg::LEVEL_W-1:0] activity;
    } t_level_pair;

    t_level_pair                  expected_levels[$];
    logic [63:0]                  floor_q[2];
    logic [63:0]                  peak_q[2];
    logic [aln_pkg::LEVEL_W-1:0]  level_q[2];
    logic [aln_pkg::SHIFT_W-1:0]  rise_sh;
    logic [aln_pkg::SHIFT_W-1:0]  fall_sh;
    logic [aln_pkg::SHIFT_W-1:0]  decay_sh;
    logic [aln_pkg::SPAN_W-1:0]   min_span_q;
    int                           fails = 0;

    // Fast attack takes ceil(3/4) of the gap, slow release ceil(1/8).
    function automatic logic [aln_pkg::LEVEL_W-1:0] ease_level(
        input logic [aln_pkg::LEVEL_W-1:0] cur,
        input logic [aln_pkg::LEVEL_W-1:0] tgt);
        logic [31:0] gap;
        logic [31:0] stride;
        if (tgt > cur) begin
            gap = 32'(tgt - cur);
            stride = (gap * 3 + 3) / 4;
            if (stride == 0) stride = 1;
            return cur + stride[aln_pkg::LEVEL_W-1:0];
        end
        if (tgt < cur) begin
            gap = 32'(cur - tgt);
            stride = (gap + 7) / 8;
            if (stride == 0) stride = 1;
            return cur - stride[aln_pkg::LEVEL_W-1:0];
        end
        return cur;
    endfunction

    function automatic logic [aln_pkg::LEVEL_W-1:0] advance_lane(
        input int lane,
        input logic [aln_pkg::IN_W-1:0] energy);
        logic [63:0] x;
        logic [63:0] sig;
        logic [63:0] decay;
        logic [63:0] span;
        logic [63:0] tgt;
        x = 64'(energy) & ENERGY_MASK;
        if (x >= floor_q[lane])
            floor_q[lane] = floor_q[lane] + ((x - floor_q[lane]) >> rise_sh);
        else
            floor_q[lane] = floor_q[lane] - ((floor_q[lane] - x) >> fall_sh);

        sig = (x > floor_q[lane]) ? x - floor_q[lane] : 64'd0;

        if (sig >= peak_q[lane]) begin
            peak_q[lane] = sig;
        end else begin
            decay = (peak_q[lane] >> decay_sh) + 64'd1;
            if (peak_q[lane] > decay) peak_q[lane] = peak_q[lane] - decay;
            else peak_q[lane] = 64'd1;
            if (sig > peak_q[lane]) peak_q[lane] = sig;
        end
        if (peak_q[lane] == 64'd0) peak_q[lane] = 64'd1;

        span = peak_q[lane];
        if (span < 64'(min_span_q)) span = 64'(min_span_q);

        // The product is formed at full width, so no wrap can occur here.
        if (sig >= span) begin
            tgt = 64'(FULL_SCALE);
        end else begin
            tgt = (sig * 64'(FULL_SCALE)) / span;
            if (tgt > 64'(FULL_SCALE)) tgt = 64'(FULL_SCALE);
        end

        level_q[lane] = ease_level(level_q[lane], tgt[aln_pkg::LEVEL_W-1:0]);
        return level_q[lane];
    endfunction

    always @(posedge i_clk) begin : monitor
        t_level_pair want;
        t_level_pair got;
        if (!i_rst_n) begin
            rise_sh    = aln_pkg::RST_FLOOR_RISE;
            fall_sh    = aln_pkg::RST_FLOOR_FALL;
            decay_sh   = aln_pkg::RST_PEAK_DECAY;
            min_span_q = aln_pkg::RST_MIN_SPAN;
            for (int k = 0; k < 2; k++) begin
                floor_q[k] = 64'd0;
                peak_q[k]  = 64'd1;
                level_q[k] = '0;
            end
            expected_levels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    aln_pkg::CFG_FLOOR_RISE: rise_sh    = i_cfg_data[aln_pkg::SHIFT_W-1:0];
                    aln_pkg::CFG_FLOOR_FALL: fall_sh    = i_cfg_data[aln_pkg::SHIFT_W-1:0];
                    aln_pkg::CFG_PEAK_DECAY: decay_sh   = i_cfg_data[aln_pkg::SHIFT_W-1:0];
                    aln_pkg::CFG_MIN_SPAN:   min_span_q = i_cfg_data[aln_pkg::SPAN_W-1:0];
                    default: ;
                endcase
            end

            if (i_out_mon.valid && i_out_mon.ready) begin
                got.music    = i_out_mon.music_level;
                got.activity = i_out_mon.activity_level;
                if (expected_levels.size() == 0) begin
                    $display("%0t: unexpected result transaction: expected none, got %0d / %0d",
                             $time, got.music, got.activity);
                    fails++;
                end else begin
                    want = expected_levels.pop_front();
                    if (got.music !== want.music) begin
                        $display("%0t: music_level mismatch: expected %0d, got %0d",
                                 $time, want.music, got.music);
                        fails++;
                    end
                    if (got.activity !== want.activity) begin
                        $display("%0t: activity_level mismatch: expected %0d, got %0d",
                                 $time, want.activity, got.activity);
                        fails++;
                    end
                end
            end

            if (i_in_mon.valid && i_in_mon.ready) begin
                want.music    = advance_lane(0, i_in_mon.music_energy);
                want.activity = advance_lane(1, i_in_mon.activity_energy);
                expected_levels.push_back(want);
            end
        end
        o_pending    <= expected_levels.size();
        o_fail_count <= fails;
    end

endmodule

// File: sim/tb_adaptive_level_normalizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_level_normalizer_core
// Drives energy pairs and register settings into the level normalizer.
// A short directed run covers field extremes and corner settings, followed by
// phases of drifting, spiking and random energies under random settings, with
// random idle bursts on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_adaptive_level_normalizer_core;

    localparam int CLK_PERIOD      = 12;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 218;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 24;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    aln_pkg::t_cfg_idx              i_cfg_idx;
    logic [aln_pkg::CFG_W-1:0]      i_cfg_data;
    int                             fail_count;
    int                             pending;

    int                             tx_gap_pct = 0;
    int                             rx_gap_pct = 0;
    logic                           rx_hold_req = 1'b0;
    logic [aln_pkg::IN_W-1:0]       drift_base[2];

    aln_in_if  in_ch();
    aln_out_if out_ch();

    adaptive_level_normalizer_core #(
        .ENERGY_WIDTH (32),
        .FULL_SCALE   (1000)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    aln_level_checker #(
        .ENERGY_WIDTH (32),
        .FULL_SCALE   (1000)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Output side: one decision on ready per clock edge. A long hold requested
    // by the stimulus is counted down here.
    initial begin : result_sink
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                hold_left = LONG_HOLD;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (idle_left > 0) begin
                out_ch.ready <= 1'b0;
                idle_left--;
            end else if ($urandom_range(0, 99) < rx_gap_pct) begin
                out_ch.ready <= 1'b0;
                idle_left = $urandom_range(1, 6) - 1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Called in the time step of a clock edge; returns in the step of the
    // edge at which the transaction is accepted, with valid still high.
    task automatic send_energies(input logic [aln_pkg::IN_W-1:0] music,
                                 input logic [aln_pkg::IN_W-1:0] activity);
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.music_energy    <= music;
        in_ch.activity_energy <= activity;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Writes all four registers on consecutive edges; unused upper data bits
    // of the shift registers carry random junk.
    task automatic load_config(input logic [aln_pkg::SHIFT_W-1:0] rise,
                               input logic [aln_pkg::SHIFT_W-1:0] fall,
                               input logic [aln_pkg::SHIFT_W-1:0] decay,
                               input logic [aln_pkg::SPAN_W-1:0] span);
        logic [aln_pkg::CFG_W-aln_pkg::SHIFT_W-1:0] junk;
        junk = (aln_pkg::CFG_W - aln_pkg::SHIFT_W)'($urandom);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= aln_pkg::CFG_FLOOR_RISE;
        i_cfg_data <= {junk, rise};
        @(posedge i_clk);
        junk = (aln_pkg::CFG_W - aln_pkg::SHIFT_W)'($urandom);
        i_cfg_idx  <= aln_pkg::CFG_FLOOR_FALL;
        i_cfg_data <= {junk, fall};
        @(posedge i_clk);
        junk = (aln_pkg::CFG_W - aln_pkg::SHIFT_W)'($urandom);
        i_cfg_idx  <= aln_pkg::CFG_PEAK_DECAY;
        i_cfg_data <= {junk, decay};
        @(posedge i_clk);
        i_cfg_idx  <= aln_pkg::CFG_MIN_SPAN;
        i_cfg_data <= span;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [aln_pkg::SHIFT_W-1:0] pick_shift();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return aln_pkg::SHIFT_W'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [aln_pkg::SPAN_W-1:0] pick_span();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'd1;
            2:       return '1;
            3, 4:    return aln_pkg::SPAN_W'($urandom_range(1, 1023));
            default: return aln_pkg::SPAN_W'($urandom);
        endcase
    endfunction

    // Mostly a slowly moving level with noise on top, so that floor, peak and
    // smoothing all see realistic trajectories; the rest is spikes, silence,
    // full scale and plain noise.
    function automatic logic [aln_pkg::IN_W-1:0] next_energy(input int lane);
        logic [aln_pkg::IN_W-1:0] noise;
        int pick;
        if ($urandom_range(0, 49) == 0)
            drift_base[lane] = $urandom >> $urandom_range(0, 31);
        noise = $urandom >> $urandom_range(8, 31);
        pick = $urandom_range(0, 99);
        if (pick < 50) return drift_base[lane] + noise;
        if (pick < 62) return drift_base[lane] << $urandom_range(1, 4);
        if (pick < 70) return '0;
        if (pick < 74) return '1;
        if (pick < 88) return $urandom;
        return $urandom_range(0, 255);
    endfunction

    initial begin : stimulus
        in_ch.valid           <= 1'b0;
        in_ch.music_energy    <= '0;
        in_ch.activity_energy <= '0;
        i_cfg_we              <= 1'b0;
        i_cfg_idx             <= aln_pkg::CFG_FLOOR_RISE;
        i_cfg_data            <= '0;
        i_rst_n               <= 1'b0;
        drift_base[0] = 32'd5000;
        drift_base[1] = 32'd80000;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_gap_pct = 30;
        rx_gap_pct = 30;

        // Reset settings: field extremes and alternating bit patterns.
        send_energies(32'h0000_0000, 32'h0000_0000);
        send_energies(32'hFFFF_FFFF, 32'h0000_0000);
        send_energies(32'h0000_0000, 32'hFFFF_FFFF);
        send_energies(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_energies(32'h0000_0000, 32'h0000_0000);
        send_energies(32'h0000_0001, 32'h0000_0001);
        send_energies(32'hAAAA_AAAA, 32'h5555_5555);
        send_energies(32'h5555_5555, 32'hAAAA_AAAA);
        wait_idle();

        // Smallest shifts: the floor snaps to the input and the peak decays fully.
        load_config('0, '0, '0, 16'd1);
        send_energies(32'd1000, 32'd2000);
        send_energies(32'd0, 32'd0);
        send_energies(32'hFFFF_FFFF, 32'd1);
        wait_idle();

        // Zero min_span: the divisor is the peak alone.
        load_config('1, '1, '1, 16'd0);
        send_energies(32'd100, 32'd100);
        send_energies(32'd200, 32'd50);
        send_energies(32'd300, 32'd300);
        send_energies(32'd5, 32'd5);
        wait_idle();

        // Largest min_span keeps small signals in the proportional range.
        load_config('1, '1, '1, 16'hFFFF);
        send_energies(32'd20000, 32'd65535);
        send_energies(32'd40000, 32'd100);
        send_energies(32'd0, 32'd0);
        wait_idle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            load_config(pick_shift(), pick_shift(), pick_shift(), pick_span());
            if (ph == RAND_PHASES - 1) begin
                tx_gap_pct = 0;
                rx_gap_pct = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                tx_gap_pct = 0;
                rx_gap_pct = $urandom_range(0, 50);
            end else begin
                tx_gap_pct = $urandom_range(0, 50);
                rx_gap_pct = $urandom_range(0, 50);
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == 1 && k == 40) rx_hold_req = 1'b1;
                send_energies(next_energy(0), next_energy(1));
            end
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
